>>> src/label_map_boundary_detect_unit_defines.svh
// Assertion macros shared by the boundary detector RTL.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef LABEL_MAP_BOUNDARY_DETECT_UNIT_DEFINES_SVH
`define LABEL_MAP_BOUNDARY_DETECT_UNIT_DEFINES_SVH

`ifndef SYNTH

`define LMBD_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lmbd: check failed");

`define LMBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbd: check failed");

`else

`define LMBD_ASSERT(lbl, expr)

`define LMBD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/lmbd_pkg.sv
package lmbd_pkg;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    localparam int CFG_BITS       = 13;
    localparam int RING_ROWS      = 3;
    localparam int MAX_HEIGHT     = 4096;
    localparam int POS_BITS       = 12;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd512;

    typedef logic [1:0] slot_t;

    // Control fields of one word on its way from issue to the compare stage.
    typedef struct packed
    {
        logic                pix;
        logic                emit;
        logic                below_en;
        logic                up_en;
        logic                fwd;
        logic                frame_end;
        slot_t               self_slot;
        slot_t               up_slot;
        slot_t               wr_slot;
        logic [POS_BITS-1:0] col;
        logic [POS_BITS-1:0] row;
    } item_t;

    function automatic slot_t slot_prev(input slot_t s);
        slot_t r;
        r = (s == 2'd0) ? 2'd2 : s - 2'd1;
        return r;
    endfunction

    function automatic slot_t slot_next(input slot_t s);
        slot_t r;
        r = (s == 2'd2) ? 2'd0 : s + 2'd1;
        return r;
    endfunction

endpackage

>>> src/lmbd_label_ram.sv
module lmbd_label_ram #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LABEL_BITS = 24
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 waddr,
    input  lmbd_pkg::slot_t                              wslot,
    input  logic [LABEL_BITS-1:0]                        wdata,
    input  logic                                         re,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 raddr,
    output logic [lmbd_pkg::RING_ROWS-1:0][LABEL_BITS-1:0] rdata
);
    import lmbd_pkg::*;

    // One word per column, one lane per ring row.
    logic [RING_ROWS-1:0][LABEL_BITS-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wslot] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/lmbd_ctrl.sv
`include "label_map_boundary_detect_unit_defines.svh"

module lmbd_ctrl #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LABEL_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [lmbd_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                                s1_busy,
    output logic                                issue_valid,
    output lmbd_pkg::item_t                     issue,
    output logic [LABEL_BITS-1:0]               issue_label,
    output logic                                mem_we,
    output logic [$clog2(MAX_WIDTH)-1:0]        mem_waddr,
    output lmbd_pkg::slot_t                     mem_wslot,
    output logic                                mem_re,
    output logic [$clog2(MAX_WIDTH)-1:0]        mem_raddr
);
    import lmbd_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [CFG_BITS-1:0] width_reg, width_next;
    logic [CFG_BITS-1:0] height_reg, height_next;
    logic [COL_W-1:0]    in_column_reg, in_column_next;
    logic [POS_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    drain_column_reg, drain_column_next;
    logic                draining_reg, draining_next;
    slot_t               in_slot_reg, in_slot_next;

    logic        accept;
    logic        cfg_write;
    logic        pix_go;
    logic        drain_go;
    logic [31:0] w32;
    logic [31:0] h32;
    logic [31:0] eff_w;
    logic [31:0] eff_h;
    logic [31:0] col_plus1;
    logic [31:0] drain_plus1;
    logic [31:0] row_plus1;
    logic        col_last;
    logic        drain_last;
    logic        row_last;
    logic [31:0] label_full;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = s1_busy;
    assign accept    = in_valid && !in_stall;
    assign pix_go    = accept && (op_t'(operation) == OP_PIXEL) && !draining_reg;
    assign drain_go  = accept && (op_t'(operation) == OP_DRAIN) && draining_reg;

    always_comb
    begin
        w32 = 32'(width_reg);
        h32 = 32'(height_reg);
        if (w32 == 32'd0)
        begin
            eff_w = 32'd1;
        end
        else if (w32 > 32'(MAX_WIDTH))
        begin
            eff_w = 32'(MAX_WIDTH);
        end
        else
        begin
            eff_w = w32;
        end
        if (h32 == 32'd0)
        begin
            eff_h = 32'd1;
        end
        else if (h32 > 32'(MAX_HEIGHT))
        begin
            eff_h = 32'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = h32;
        end
    end

    assign col_plus1   = 32'(in_column_reg) + 32'd1;
    assign drain_plus1 = 32'(drain_column_reg) + 32'd1;
    assign row_plus1   = 32'(in_row_reg) + 32'd1;
    assign col_last    = col_plus1 >= eff_w;
    assign drain_last  = drain_plus1 >= eff_w;
    assign row_last    = row_plus1 >= eff_h;
    assign label_full  = 32'({blue, green, red});
    assign issue_label = label_full[LABEL_BITS-1:0];

    // Memory ports: write the new label, prefetch the right-hand column.
    assign mem_we    = pix_go;
    assign mem_waddr = in_column_reg;
    assign mem_wslot = in_slot_reg;
    assign mem_re    = pix_go || drain_go;

    always_comb
    begin
        if (draining_reg)
        begin
            mem_raddr = drain_last ? '0 : COL_W'(drain_plus1);
        end
        else
        begin
            mem_raddr = col_last ? '0 : COL_W'(col_plus1);
        end
    end

    always_comb
    begin
        issue_valid     = pix_go || drain_go;
        issue           = '0;
        issue.pix       = pix_go;
        issue.wr_slot   = in_slot_reg;
        if (draining_reg)
        begin
            issue.emit      = 1'b1;
            issue.below_en  = 1'b0;
            issue.up_en     = in_row_reg != '0;
            issue.fwd       = 1'b0;
            issue.frame_end = drain_last;
            issue.self_slot = in_slot_reg;
            issue.up_slot   = slot_prev(in_slot_reg);
            issue.col       = POS_BITS'(drain_column_reg);
            issue.row       = in_row_reg;
        end
        else
        begin
            issue.emit      = in_row_reg != '0;
            issue.below_en  = 1'b1;
            issue.up_en     = in_row_reg > 12'd1;
            issue.fwd       = mem_raddr == in_column_reg;
            issue.frame_end = 1'b0;
            issue.self_slot = slot_prev(in_slot_reg);
            issue.up_slot   = slot_prev(slot_prev(in_slot_reg));
            issue.col       = POS_BITS'(in_column_reg);
            issue.row       = in_row_reg - 12'd1;
        end
    end

    always_comb
    begin
        width_next        = width_reg;
        height_next       = height_reg;
        in_column_next    = in_column_reg;
        in_row_next       = in_row_reg;
        drain_column_next = drain_column_reg;
        draining_next     = draining_reg;
        in_slot_next      = in_slot_reg;
        if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
            // A write to the width or height register restarts the frame.
            if ((reg_index_t'(cfg_index) == REG_IMAGE_WIDTH) ||
                (reg_index_t'(cfg_index) == REG_IMAGE_HEIGHT))
            begin
                in_column_next    = '0;
                in_row_next       = '0;
                drain_column_next = '0;
                draining_next     = 1'b0;
                in_slot_next      = 2'd0;
            end
        end
        else if (pix_go)
        begin
            if (col_last)
            begin
                in_column_next = '0;
                if (row_last)
                begin
                    draining_next     = 1'b1;
                    drain_column_next = '0;
                end
                else
                begin
                    in_row_next  = in_row_reg + 12'd1;
                    in_slot_next = slot_next(in_slot_reg);
                end
            end
            else
            begin
                in_column_next = COL_W'(col_plus1);
            end
        end
        else if (drain_go)
        begin
            if (drain_last)
            begin
                in_column_next    = '0;
                in_row_next       = '0;
                drain_column_next = '0;
                draining_next     = 1'b0;
                in_slot_next      = 2'd0;
            end
            else
            begin
                drain_column_next = COL_W'(drain_plus1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= WIDTH_RESET;
            height_reg       <= HEIGHT_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            drain_column_reg <= '0;
            draining_reg     <= 1'b0;
            in_slot_reg      <= 2'd0;
        end
        else
        begin
            width_reg        <= width_next;
            height_reg       <= height_next;
            in_column_reg    <= in_column_next;
            in_row_reg       <= in_row_next;
            drain_column_reg <= drain_column_next;
            draining_reg     <= draining_next;
            in_slot_reg      <= in_slot_next;
        end
    end

    `LMBD_ASSERT(a_slot_range, in_slot_reg != 2'd3)
    `LMBD_ASSERT(a_drain_col_zero, !draining_reg || (in_column_reg == '0))
    `LMBD_ASSERT(a_fwd_only_width_one, !(pix_go && issue.fwd) || (eff_w == 32'd1))

endmodule

>>> src/lmbd_judge.sv
`include "label_map_boundary_detect_unit_defines.svh"

module lmbd_judge #(
    parameter int LABEL_BITS = 24
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            issue_valid,
    input  lmbd_pkg::item_t                                 issue,
    input  logic [LABEL_BITS-1:0]                           issue_label,
    input  logic [lmbd_pkg::RING_ROWS-1:0][LABEL_BITS-1:0]  rdata,
    output logic                                            s1_busy,
    output logic                                            out_valid,
    input  logic                                            out_stall,
    output logic                                            is_boundary,
    output logic [lmbd_pkg::POS_BITS-1:0]                   pixel_column,
    output logic [lmbd_pkg::POS_BITS-1:0]                   pixel_row,
    output logic                                            frame_end
);
    import lmbd_pkg::*;

    typedef logic [RING_ROWS-1:0][LABEL_BITS-1:0] column_word_t;

    logic                  s1_valid_reg, s1_valid_next;
    item_t                 item_reg;
    logic [LABEL_BITS-1:0] label_reg;
    column_word_t          prev_reg, prev_next;
    column_word_t          cur_reg, cur_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_boundary_reg;
    logic [POS_BITS-1:0]   out_column_reg;
    logic [POS_BITS-1:0]   out_row_reg;
    logic                  out_end_reg;

    logic                  s1_go;
    logic                  s1_fire;
    logic [LABEL_BITS-1:0] self_label;
    logic                  diff;

    assign s1_go   = !out_valid_reg || !out_stall;
    assign s1_fire = s1_valid_reg && s1_go;
    assign s1_busy = s1_valid_reg && !s1_go;

    // Window: prev holds column c-1, cur column c, rdata column c+1.
    always_comb
    begin
        self_label = cur_reg[item_reg.self_slot];
        diff = (prev_reg[item_reg.self_slot] != self_label) ||
               (rdata[item_reg.self_slot] != self_label) ||
               (item_reg.up_en && (cur_reg[item_reg.up_slot] != self_label)) ||
               (item_reg.below_en && (label_reg != self_label));
    end

    always_comb
    begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        if (s1_fire)
        begin
            prev_next = cur_reg;
            if (item_reg.pix)
            begin
                prev_next[item_reg.wr_slot] = label_reg;
            end
            cur_next = rdata;
            // Single-column image: the prefetch hit the column just written.
            if (item_reg.fwd)
            begin
                cur_next[item_reg.wr_slot] = label_reg;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue_valid)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire && item_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_valid)
        begin
            item_reg  <= issue;
            label_reg <= issue_label;
        end
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        if (s1_fire && item_reg.emit)
        begin
            out_boundary_reg <= diff;
            out_column_reg   <= item_reg.col;
            out_row_reg      <= item_reg.row;
            out_end_reg      <= item_reg.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_boundary  = out_boundary_reg;
    assign pixel_column = out_column_reg;
    assign pixel_row    = out_row_reg;
    assign frame_end    = out_end_reg;

    `LMBD_ASSERT(a_no_issue_when_busy, !(issue_valid && s1_busy))
    `LMBD_ASSERT(a_end_from_drain, !(s1_valid_reg && item_reg.frame_end && item_reg.below_en))
    `LMBD_ASSERT(a_up_slot_differs,
        !(s1_valid_reg && item_reg.up_en && (item_reg.up_slot == item_reg.self_slot)))
    `LMBD_ASSERT_NEXT(a_emit_lands, s1_fire && item_reg.emit, out_valid_reg)

endmodule

>>> src/label_map_boundary_detect_unit.sv
// Each word passes the compare stage register and then the output register;
// verdicts for a row come out while the next row streams in, the last row on drain words.
// Throughput: one word per clock when in_stall is low, set by the single-write, single-read label memory.
// Reset clears counters, drain mode, the compare stage and the output register;
// registers return to width 1024 and height 512. The label memory is not cleared.
module label_map_boundary_detect_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LABEL_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_boundary,
    output logic [lmbd_pkg::POS_BITS-1:0]       pixel_column,
    output logic [lmbd_pkg::POS_BITS-1:0]       pixel_row,
    output logic                                frame_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [lmbd_pkg::CFG_BITS-1:0]       cfg_data
);
    import lmbd_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                                 s1_busy;
    logic                                 issue_valid;
    item_t                                issue;
    logic [LABEL_BITS-1:0]                issue_label;
    logic                                 mem_we;
    logic [COL_W-1:0]                     mem_waddr;
    slot_t                                mem_wslot;
    logic                                 mem_re;
    logic [COL_W-1:0]                     mem_raddr;
    logic [RING_ROWS-1:0][LABEL_BITS-1:0] mem_rdata;

    lmbd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s1_busy     (s1_busy),
        .issue_valid (issue_valid),
        .issue       (issue),
        .issue_label (issue_label),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wslot   (mem_wslot),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr)
    );

    lmbd_label_ram #(
        .MAX_WIDTH  (MAX_WIDTH),
        .LABEL_BITS (LABEL_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wslot (mem_wslot),
        .wdata (issue_label),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lmbd_judge #(
        .LABEL_BITS (LABEL_BITS)
    ) u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .issue_label  (issue_label),
        .rdata        (mem_rdata),
        .s1_busy      (s1_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_boundary  (is_boundary),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .frame_end    (frame_end)
    );

endmodule
